[hw/rtl/sgm_pkg.sv]
`default_nettype none

package sgm_pkg;

  localparam int NUM_INPUTS = 4;

  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 16;
  localparam int GPROD_W    = 2 * GAIN_W;
  localparam int PROD_SHIFT = 28;
  // Scaled magnitude: the full product never reaches bit 63.
  localparam int Q_W        = SAMPLE_W + GPROD_W - 1 - PROD_SHIFT;
  localparam int SUM_W      = SAMPLE_W + $clog2(NUM_INPUTS);

  localparam int ACTIVE_W   = 3;
  localparam int FMT_W      = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int CFG_IDX_W  = $clog2(NUM_INPUTS + 3);

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER    = CFG_IDX_W'(0);
  localparam int                   CFG_GAIN_BASE = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = CFG_IDX_W'(NUM_INPUTS + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT    = CFG_IDX_W'(NUM_INPUTS + 2);

  // Sample format codes
  localparam logic [FMT_W-1:0] FMT_S8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic             active;
  } lane_cfg_t;

  typedef struct packed {
    logic valid;
    logic block_end;
  } tag_t;

  // Positive limit of a format; the unused code gives zero.
  function automatic logic [SAMPLE_W-1:0] fmt_hi(input logic [FMT_W-1:0] fmt);
    logic [SAMPLE_W-1:0] hi;
    case (fmt)
      FMT_S8:  hi = 32'h0000_007F;
      FMT_S16: hi = 32'h0000_7FFF;
      FMT_S32: hi = 32'h7FFF_FFFF;
      default: hi = '0;
    endcase
    return hi;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sgm_lane.sv]
`default_nettype none

module sgm_lane (
  input  wire logic                           clk,
  input  wire sgm_pkg::lane_cfg_t             cfg,
  input  wire logic [sgm_pkg::GAIN_W-1:0]     master_gain,
  input  wire logic [sgm_pkg::GAIN_W-1:0]     gain,
  input  wire logic signed [sgm_pkg::SAMPLE_W-1:0] sample,
  output logic signed [sgm_pkg::SAMPLE_W-1:0] term
);
  import sgm_pkg::*;

  logic [GPROD_W-1:0]  gprod;
  logic [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0] mag_next;
  logic [SAMPLE_W-1:0] mag;
  logic                neg0;
  logic                act0;
  logic [63:0]         prod;
  logic [Q_W-1:0]      q;
  logic                neg1;
  logic                act1;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] limit;
  logic [SAMPLE_W-1:0] qc;
  logic [SAMPLE_W-1:0] term_next;

  // Sign-extend the low bits of the selected format
  always_comb begin
    case (cfg.fmt)
      FMT_S8:  x = {{(SAMPLE_W-8){sample[7]}}, sample[7:0]};
      FMT_S16: x = {{(SAMPLE_W-16){sample[15]}}, sample[15:0]};
      default: x = sample;
    endcase
    mag_next = x[SAMPLE_W-1] ? SAMPLE_W'(-x) : x;
  end

  assign prod = 64'(mag) * 64'(gprod);

  // Clamp on the magnitude: negative side reaches one step further
  always_comb begin
    hi        = fmt_hi(cfg.fmt);
    limit     = neg1 ? SAMPLE_W'(hi + 1'b1) : hi;
    qc        = (q > Q_W'(limit)) ? limit : q[SAMPLE_W-1:0];
    term_next = neg1 ? SAMPLE_W'(-qc) : qc;
  end

  always_ff @(posedge clk) begin
    gprod <= GPROD_W'(master_gain) * GPROD_W'(gain);
    mag   <= mag_next;
    neg0  <= x[SAMPLE_W-1];
    act0  <= cfg.active;
    q     <= prod[Q_W+PROD_SHIFT-1:PROD_SHIFT];
    neg1  <= neg0;
    act1  <= act0;
    term  <= act1 ? signed'(term_next) : '0;
  end

endmodule

`default_nettype wire

[hw/rtl/sgm_merge.sv]
`default_nettype none

module sgm_merge (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire sgm_pkg::tag_t                                   tag_in,
  input  wire logic [sgm_pkg::NUM_INPUTS-1:0][sgm_pkg::SAMPLE_W-1:0] terms,
  input  wire logic [sgm_pkg::FMT_W-1:0]                       fmt,
  output logic                                                 done,
  output logic signed [sgm_pkg::SAMPLE_W-1:0]                  mixed_sample,
  output logic                                                 block_end_out
);
  import sgm_pkg::*;

  logic signed [SUM_W-1:0]    sum_next;
  logic signed [SUM_W-1:0]    sum;
  tag_t                       tag;
  logic signed [SUM_W-1:0]    hi_s;
  logic signed [SUM_W-1:0]    lo_s;
  logic signed [SAMPLE_W-1:0] out_next;

  always_comb begin
    sum_next = '0;
    for (int j = 0; j < NUM_INPUTS; j++) begin
      sum_next = sum_next + SUM_W'(signed'(terms[j]));
    end
  end

  // Negative limit is one step beyond the positive one
  always_comb begin
    hi_s = signed'(SUM_W'(fmt_hi(fmt)));
    lo_s = ~hi_s;
    if (fmt != FMT_S8 && fmt != FMT_S16 && fmt != FMT_S32) begin
      out_next = '0;
    end else if (sum > hi_s) begin
      out_next = SAMPLE_W'(hi_s);
    end else if (sum < lo_s) begin
      out_next = SAMPLE_W'(lo_s);
    end else begin
      out_next = SAMPLE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    sum           <= sum_next;
    mixed_sample  <= out_next;
    block_end_out <= tag.block_end;
    if (rst) begin
      tag.valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      tag.valid <= tag_in.valid;
      done      <= tag.valid;
    end
    tag.block_end <= tag_in.block_end;
  end

  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed({mixed_sample[SAMPLE_W-1], mixed_sample})
              <= $signed({1'b0, fmt_hi($past(fmt))}))
          && ($signed({mixed_sample[SAMPLE_W-1], mixed_sample})
              >= -$signed({1'b0, fmt_hi($past(fmt))}) - 1))
    else $error("mixed sample outside the format range");

  a_unused_fmt_silent: assert property (@(posedge clk) disable iff (rst)
    done && $past(fmt) != FMT_S8 && $past(fmt) != FMT_S16 && $past(fmt) != FMT_S32
      |-> mixed_sample == '0)
    else $error("unused format did not give silence");

endmodule

`default_nettype wire

[hw/rtl/saturating_gain_mixer_core.sv]
`default_nettype none

// Four-input saturating mixer with master and per-input Q2.14 gain.
// One sample set is taken every clock: busy never rises, so start alone
// begins a transfer. Each result appears on mixed_sample and block_end_out,
// with done high for exactly one cycle; results cannot be held off and must
// be taken when done is high. Each sample set passes through the lanes (sign
// extension, pipelined 32x32 gain multiply, clamp), then a two-stage sum and
// final clamp. Registers are written through cfg_we/cfg_index/cfg_data and
// take effect for samples started on the following cycle; write them only
// while no result is outstanding.

module saturating_gain_mixer_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [sgm_pkg::SAMPLE_W-1:0]    sample_0,
  input  wire logic signed [sgm_pkg::SAMPLE_W-1:0]    sample_1,
  input  wire logic signed [sgm_pkg::SAMPLE_W-1:0]    sample_2,
  input  wire logic signed [sgm_pkg::SAMPLE_W-1:0]    sample_3,
  input  wire logic                                   block_end,
  output logic                                        done,
  output logic signed [sgm_pkg::SAMPLE_W-1:0]         mixed_sample,
  output logic                                        block_end_out,
  input  wire logic                                   cfg_we,
  input  wire logic [sgm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import sgm_pkg::*;

  logic [GAIN_W-1:0]   master_gain;
  logic [GAIN_W-1:0]   gain [NUM_INPUTS];
  logic [ACTIVE_W-1:0] active_inputs;
  logic [FMT_W-1:0]    sample_format;

  logic                                   accept;
  tag_t                                   tag_pipe [3];
  logic signed [SAMPLE_W-1:0]             samples [NUM_INPUTS];
  logic [NUM_INPUTS-1:0][SAMPLE_W-1:0]    terms;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain   <= GAIN_UNITY;
      active_inputs <= ACTIVE_RESET;
      sample_format <= FMT_S16;
      for (int j = 0; j < NUM_INPUTS; j++) begin
        gain[j] <= GAIN_UNITY;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_MASTER) begin
        master_gain <= cfg_data;
      end
      if (cfg_index == CFG_ACTIVE) begin
        active_inputs <= cfg_data[ACTIVE_W-1:0];
      end
      if (cfg_index == CFG_FORMAT) begin
        sample_format <= cfg_data[FMT_W-1:0];
      end
      for (int j = 0; j < NUM_INPUTS; j++) begin
        if (cfg_index == CFG_IDX_W'(CFG_GAIN_BASE + j)) begin
          gain[j] <= cfg_data;
        end
      end
    end
  end

  // Tags follow the samples through the three lane stages
  always_ff @(posedge clk) begin
    tag_pipe[0].block_end <= block_end;
    tag_pipe[1].block_end <= tag_pipe[0].block_end;
    tag_pipe[2].block_end <= tag_pipe[1].block_end;
    if (rst) begin
      tag_pipe[0].valid <= 1'b0;
      tag_pipe[1].valid <= 1'b0;
      tag_pipe[2].valid <= 1'b0;
    end else begin
      tag_pipe[0].valid <= accept;
      tag_pipe[1].valid <= tag_pipe[0].valid;
      tag_pipe[2].valid <= tag_pipe[1].valid;
    end
  end

  for (genvar j = 0; j < NUM_INPUTS; j++) begin : g_lane
    lane_cfg_t lane_cfg;

    assign lane_cfg.fmt    = sample_format;
    assign lane_cfg.active = active_inputs > ACTIVE_W'(j);

    sgm_lane u_lane (
      .clk         (clk),
      .cfg         (lane_cfg),
      .master_gain (master_gain),
      .gain        (gain[j]),
      .sample      (samples[j]),
      .term        (terms[j])
    );
  end

  sgm_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .tag_in        (tag_pipe[2]),
    .terms         (terms),
    .fmt           (sample_format),
    .done          (done),
    .mixed_sample  (mixed_sample),
    .block_end_out (block_end_out)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching transfer");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy, 5) && !$past(rst, 5) && !$past(rst, 4) && !$past(rst, 3)
      && !$past(rst, 2) && !$past(rst, 1) |-> done)
    else $error("transfer produced no result");

  a_block_end_tracks: assert property (@(posedge clk) disable iff (rst)
    done |-> block_end_out == $past(block_end, 5))
    else $error("block end flag out of step with its sample");

endmodule

`default_nettype wire

[tb/sgm_mix_checker.sv]
`default_nettype none

module sgm_mix_checker
  import sgm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic [SAMPLE_W-1:0]        sample_0,
  input  wire logic [SAMPLE_W-1:0]        sample_1,
  input  wire logic [SAMPLE_W-1:0]        sample_2,
  input  wire logic [SAMPLE_W-1:0]        sample_3,
  input  wire logic                       block_end,
  input  wire logic                       done,
  input  wire logic [SAMPLE_W-1:0]        mixed_sample,
  input  wire logic                       block_end_out,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  output int                              fail_count,
  output int                              outstanding
);

  localparam int REPORT_LIMIT = 10;
  localparam int EXP_DEPTH    = 64;
  localparam int EXP_IDX_W    = $clog2(EXP_DEPTH);

  typedef struct packed {
    logic [SAMPLE_W-1:0] mix;
    logic                last;
  } mix_out_t;

  // Shadow copy of the block's registers
  logic [GAIN_W-1:0]   master_gain_q;
  logic [GAIN_W-1:0]   lane_gain_q [NUM_INPUTS];
  logic [ACTIVE_W-1:0] active_q;
  logic [FMT_W-1:0]    fmt_q;

  // Expected results in transfer order
  mix_out_t             expected_mem [EXP_DEPTH];
  logic [EXP_IDX_W-1:0] exp_rd_ptr;
  logic [EXP_IDX_W-1:0] exp_wr_ptr;
  int                   exp_count;

  function automatic logic [SAMPLE_W-1:0] predict_mix(
    input logic [NUM_INPUTS-1:0][SAMPLE_W-1:0] lanes
  );
    longint      hi, lo, x, term, sum;
    logic [63:0] mag, prod;
    int          n, j;
    sum = 0;
    case (fmt_q)
      FMT_S8:  hi = 127;
      FMT_S16: hi = 32767;
      FMT_S32: hi = 64'sd2147483647;
      default: return '0;
    endcase
    lo = -hi - 1;
    n  = (active_q > NUM_INPUTS) ? NUM_INPUTS : int'(active_q);
    for (j = 0; j < n; j++) begin
      case (fmt_q)
        FMT_S8:  x = $signed(lanes[j][7:0]);
        FMT_S16: x = $signed(lanes[j][15:0]);
        default: x = $signed(lanes[j]);
      endcase
      // scale the magnitude so the shift truncates toward zero
      mag  = (x < 0) ? 64'(-x) : 64'(x);
      prod = mag * (64'(master_gain_q) * 64'(lane_gain_q[j]));
      term = longint'(prod >> PROD_SHIFT);
      if (x < 0) term = -term;
      if (term > hi) term = hi;
      if (term < lo) term = lo;
      sum += term;
    end
    if (sum > hi) sum = hi;
    if (sum < lo) sum = lo;
    return sum[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    mix_out_t want;
    if (rst) begin
      master_gain_q = GAIN_UNITY;
      for (int j = 0; j < NUM_INPUTS; j++) lane_gain_q[j] = GAIN_UNITY;
      active_q = ACTIVE_RESET;
      fmt_q    = FMT_S16;
      exp_rd_ptr = '0;
      exp_wr_ptr = '0;
      exp_count  = 0;
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (done) begin
        if (exp_count == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("unexpected result: sample %0d end %0b",
                     $signed(mixed_sample), block_end_out);
          fail_count++;
        end else begin
          want       = expected_mem[exp_rd_ptr];
          exp_rd_ptr = exp_rd_ptr + 1'b1;
          exp_count--;
          if (mixed_sample !== want.mix || block_end_out !== want.last) begin
            if (fail_count < REPORT_LIMIT)
              $display("mix mismatch: expected sample %0d end %0b, got sample %0d end %0b",
                       $signed(want.mix), want.last, $signed(mixed_sample), block_end_out);
            fail_count++;
          end
        end
      end
      // predict with the settings in force before any write on this edge
      if (start && !busy) begin
        want.mix  = predict_mix({sample_3, sample_2, sample_1, sample_0});
        want.last = block_end;
        if (exp_count == EXP_DEPTH) begin
          if (fail_count < REPORT_LIMIT)
            $display("too many transfers in flight: expected at most %0d, got %0d",
                     EXP_DEPTH, exp_count + 1);
          fail_count++;
        end else begin
          expected_mem[exp_wr_ptr] = want;
          exp_wr_ptr = exp_wr_ptr + 1'b1;
          exp_count++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MASTER)
          master_gain_q = cfg_data;
        else if (cfg_index == CFG_ACTIVE)
          active_q = cfg_data[ACTIVE_W-1:0];
        else if (cfg_index == CFG_FORMAT)
          fmt_q = cfg_data[FMT_W-1:0];
        for (int j = 0; j < NUM_INPUTS; j++)
          if (cfg_index == CFG_IDX_W'(CFG_GAIN_BASE + j))
            lane_gain_q[j] = cfg_data;
      end
      outstanding <= exp_count;
    end
  end

endmodule

`default_nettype wire

[tb/saturating_gain_mixer_core_tb.sv]
`default_nettype none

module saturating_gain_mixer_core_tb;
  import sgm_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1400;

  localparam logic [FMT_W-1:0]     FMT_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(NUM_INPUTS + 3);

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  logic [SAMPLE_W-1:0]       sample_0  = '0;
  logic [SAMPLE_W-1:0]       sample_1  = '0;
  logic [SAMPLE_W-1:0]       sample_2  = '0;
  logic [SAMPLE_W-1:0]       sample_3  = '0;
  logic                      block_end = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;
  logic                      busy;
  logic                      done;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic                      block_end_out;

  int                        fail_count;
  int                        outstanding;
  int                        stall_cycles = 0;
  bit                        idle_enable  = 1'b1;
  logic [FMT_W-1:0]          cur_fmt      = FMT_S16;

  always #CLK_HALF clk = ~clk;

  saturating_gain_mixer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample_0      (sample_0),
    .sample_1      (sample_1),
    .sample_2      (sample_2),
    .sample_3      (sample_3),
    .block_end     (block_end),
    .done          (done),
    .mixed_sample  (mixed_sample),
    .block_end_out (block_end_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sgm_mix_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample_0      (sample_0),
    .sample_1      (sample_1),
    .sample_2      (sample_2),
    .sample_3      (sample_3),
    .block_end     (block_end),
    .done          (done),
    .mixed_sample  (mixed_sample),
    .block_end_out (block_end_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Watchdog: any transfer, result or register write counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_lane(input logic [FMT_W-1:0] fmt);
    logic [SAMPLE_W-1:0] mask, v;
    int                  w;
    case (fmt)
      FMT_S8:  w = 8;
      FMT_S16: w = 16;
      default: w = 32;
    endcase
    mask = (w == 32) ? '1 : (32'd1 << w) - 32'd1;
    case ($urandom_range(9))
      4:       v = (32'd1 << (w - 1)) - 32'd1;
      5:       v = 32'd1 << (w - 1);
      6:       v = $urandom_range(15);
      7:       v = -$urandom_range(15);
      8:       v = $urandom_range(2) - 1;
      default: v = $urandom;
    endcase
    // unused upper bits get noise
    return ($urandom & ~mask) | (v & mask);
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_UNITY;
      3:       return GAIN_W'($urandom_range(32768));
      default: return GAIN_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [FMT_W-1:0] rand_fmt();
    case ($urandom_range(9))
      0, 1, 2: return FMT_S8;
      3, 4, 5: return FMT_S16;
      6, 7, 8: return FMT_S32;
      default: return FMT_UNUSED;
    endcase
  endfunction

  // Hold start high across back-to-back transfers; drop it only for a gap
  task automatic transfer(input logic [SAMPLE_W-1:0] s0, s1, s2, s3, input logic last);
    if (idle_enable)
      while ($urandom_range(99) < 28) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start     <= 1'b1;
    sample_0  <= s0;
    sample_1  <= s1;
    sample_2  <= s2;
    sample_3  <= s3;
    block_end <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] master,
                               input logic [NUM_INPUTS-1:0][GAIN_W-1:0] gains,
                               input logic [ACTIVE_W-1:0] active,
                               input logic [FMT_W-1:0] fmt,
                               input bit poke_unmapped);
    logic [CFG_DATA_W-1:0] noise;
    int                    j;
    drain();
    write_reg(CFG_MASTER, master);
    for (j = 0; j < NUM_INPUTS; j++)
      write_reg(CFG_IDX_W'(CFG_GAIN_BASE + j), gains[j]);
    noise = CFG_DATA_W'($urandom);
    write_reg(CFG_ACTIVE, {noise[CFG_DATA_W-1:ACTIVE_W], active});
    noise = CFG_DATA_W'($urandom);
    write_reg(CFG_FORMAT, {noise[CFG_DATA_W-1:FMT_W], fmt});
    // a write past the last register must leave everything alone
    if (poke_unmapped) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    cfg_we  <= 1'b0;
    cur_fmt  = fmt;
  endtask

  initial begin
    int items;
    int phase_len;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: s16, unity gains, all inputs
    transfer(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    transfer(32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 1'b1);
    transfer(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0);
    transfer(32'h1234_7FFF, 32'hABCD_8000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    transfer(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b0);

    // Full-scale gains at s32: full-scale inputs clamp
    load_settings('1, {4{16'hFFFF}}, 3'd4, FMT_S32, 1'b0);
    transfer(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    transfer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    transfer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    transfer(32'h0000_0010, 32'hFFFF_FFF0, 32'h0100_0000, 32'h0, 1'b1);

    // s8, too many active inputs counts as all of them
    load_settings('1, {16'h2000, 16'hFFFF, 16'h4000, 16'h0000}, 3'd7, FMT_S8, 1'b0);
    transfer(32'hFFFF_FF7F, 32'h0000_007F, 32'h1234_5680, 32'h0000_0040, 1'b0);
    transfer(32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 1'b1);
    transfer(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD, 1'b0);

    // No active inputs: silence
    load_settings(GAIN_UNITY, {4{GAIN_UNITY}}, 3'd0, FMT_S16, 1'b0);
    transfer(32'h0000_7FFF, 32'h0000_1234, 32'hFFFF_8000, 32'h0000_0001, 1'b1);
    transfer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    // Unused format code: silence
    load_settings(GAIN_UNITY, {4{GAIN_UNITY}}, 3'd4, FMT_UNUSED, 1'b0);
    transfer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_7FFF, 32'h0000_007F, 1'b0);
    transfer(32'h8000_0000, 32'h0000_0001, 32'hFFFF_8000, 32'h0000_0080, 1'b1);

    // Write beyond the registers, then zero master gain
    load_settings(GAIN_UNITY, {4{GAIN_UNITY}}, 3'd4, FMT_S16, 1'b1);
    transfer(32'h0000_1000, 32'h0000_2000, 32'hFFFF_F000, 32'h0000_0003, 1'b0);
    load_settings('0, {4{16'hFFFF}}, 3'd4, FMT_S32, 1'b0);
    transfer(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);

    // Truncation toward zero on half gain, three inputs
    load_settings(GAIN_UNITY, {16'h6000, 16'h0001, 16'h2000, 16'h2000}, 3'd3, FMT_S16, 1'b0);
    transfer(32'hFFFF_FFFD, 32'h0000_0003, 32'h0000_7FFF, 32'h0000_0005, 1'b0);
    transfer(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_8000, 32'h0000_7FFF, 1'b1);

    // Random phases, each with fresh settings; one long stretch without random gaps
    items = 0;
    while (items < RANDOM_ITEMS) begin
      idle_enable = !(items >= 500 && items < 800);
      load_settings(rand_gain(), {rand_gain(), rand_gain(), rand_gain(), rand_gain()},
                    ($urandom_range(9) > 7) ? 3'd4 : 3'($urandom_range(7)),
                    rand_fmt(), $urandom_range(7) == 0);
      phase_len = $urandom_range(40, 160);
      if (phase_len > RANDOM_ITEMS - items) phase_len = RANDOM_ITEMS - items;
      repeat (phase_len) begin
        transfer(rand_lane(cur_fmt), rand_lane(cur_fmt), rand_lane(cur_fmt),
                 rand_lane(cur_fmt), $urandom_range(15) == 0);
        items++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
